FILE: rtl/vrm_pkg.sv
// ----------------------------------------------------------------------------
// vrm_pkg
// Shared types and constants of the voxel ray marcher.
// ----------------------------------------------------------------------------
package vrm_pkg;

   localparam int AXES      = 3;
   localparam int COORD_IN_W = 7;
   localparam int DIR_W     = 16;
   localparam int COLOUR_W  = 4;
   localparam int STEP_W    = 8;

   localparam logic [STEP_W-1:0] RENDER_DIST_RESET = 8'd50;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } opcode_type;

   // one ray step travelling down the pipe
   typedef struct packed {
      logic              valid;
      logic              outside;
      logic              last;
      logic [STEP_W-1:0] step;
   } probe_type;

endpackage

FILE: rtl/vrm_if.sv
// ----------------------------------------------------------------------------
// vrm_if
// Request and response channels of the voxel ray marcher.
// ----------------------------------------------------------------------------
interface vrm_req_if import vrm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   opcode_type                opcode;
   logic [COORD_IN_W-1:0]     voxel_x;
   logic [COORD_IN_W-1:0]     voxel_y;
   logic [COORD_IN_W-1:0]     voxel_z;
   logic [COLOUR_W-1:0]       voxel_value;
   logic [COORD_IN_W-1:0]     origin_x;
   logic [COORD_IN_W-1:0]     origin_y;
   logic [COORD_IN_W-1:0]     origin_z;
   logic signed [DIR_W-1:0]   dir_x;
   logic signed [DIR_W-1:0]   dir_y;
   logic signed [DIR_W-1:0]   dir_z;

   modport source (
      output valid, opcode, voxel_x, voxel_y, voxel_z, voxel_value,
             origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      input  ready
   );
   modport sink (
      input  valid, opcode, voxel_x, voxel_y, voxel_z, voxel_value,
             origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
      output ready
   );
endinterface

interface vrm_rsp_if import vrm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] colour;
   logic                hit;
   logic                out_of_range;
   logic [STEP_W-1:0]   steps_taken;

   modport source (
      output valid, colour, hit, out_of_range, steps_taken,
      input  ready
   );
   modport sink (
      input  valid, colour, hit, out_of_range, steps_taken,
      output ready
   );
endinterface

FILE: rtl/vrm_voxel_ram.sv
// ----------------------------------------------------------------------------
// vrm_voxel_ram
// Voxel colour store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vrm_voxel_ram import vrm_pkg::*; #(
   parameter int GRID_SIZE = 128,
   localparam int AW = 3 * $clog2(GRID_SIZE)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [COLOUR_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic [COLOUR_W-1:0] rd_data
);

   logic [COLOUR_W-1:0] voxel_mem [2**AW];
   logic [COLOUR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         voxel_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while the pipe is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= voxel_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/vrm_ray_step.sv
// ----------------------------------------------------------------------------
// vrm_ray_step
// Ray position accumulator and rounding stage; issues one voxel address
// per step.
// ----------------------------------------------------------------------------
module vrm_ray_step import vrm_pkg::*; #(
   parameter int GRID_SIZE     = 128,
   parameter int DIR_FRAC_BITS = 14,
   localparam int CW = $clog2(GRID_SIZE),
   localparam int AW = 3 * CW
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [COORD_IN_W-1:0]   origin [AXES],
   input  logic signed [DIR_W-1:0] dir [AXES],
   input  logic [STEP_W-1:0]       limit,
   input  logic                    stall,
   input  logic                    flush,
   output logic                    active,
   output probe_type               probe,
   output logic [AW-1:0]           addr
);

   localparam int F      = DIR_FRAC_BITS;
   localparam int SPAN_W = (COORD_IN_W + F > STEP_W + DIR_W - 1) ?
                           COORD_IN_W + F : STEP_W + DIR_W - 1;
   localparam int PW     = SPAN_W + 2;
   localparam int RW     = PW + 1 - F;
   localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);

   logic signed [PW-1:0]    pos_ff [AXES];
   logic signed [PW-1:0]    pos_in [AXES];
   logic signed [DIR_W-1:0] dir_ff [AXES];
   logic signed [DIR_W-1:0] dir_in [AXES];
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    active_ff, active_in;
   logic                    last_step;

   logic [PW-1:0]           mag  [AXES];
   logic [PW:0]             rsum [AXES];
   logic [RW-1:0]           rnd  [AXES];
   logic [CW-1:0]           coord [AXES];
   logic [AXES-1:0]         out_axis;

   probe_type               probe_ff, probe_in;
   logic [AW-1:0]           addr_ff, addr_in;

   assign last_step = (step_ff == limit);

   // position = origin * 2^F + step * dir, kept as a running sum
   always_comb begin
      pos_in    = pos_ff;
      dir_in    = dir_ff;
      step_in   = step_ff;
      active_in = active_ff;
      if (start) begin
         for (int a = 0; a < AXES; a++) begin
            pos_in[a] = $signed(PW'(origin[a]) << F) + PW'(dir[a]);
         end
         dir_in    = dir;
         step_in   = STEP_W'(1);
         active_in = 1'b1;
      end else if (flush) begin
         active_in = 1'b0;
      end else if (active_ff && !stall) begin
         for (int a = 0; a < AXES; a++) begin
            pos_in[a] = pos_ff[a] + PW'(dir_ff[a]);
         end
         step_in = step_ff + STEP_W'(1);
         if (last_step) begin
            active_in = 1'b0;
         end
      end
   end

   // round to nearest, ties away from zero; a negative value that rounds
   // to zero is still inside the grid
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         mag[a]      = pos_ff[a][PW-1] ? PW'(-pos_ff[a]) : PW'(pos_ff[a]);
         rsum[a]     = {1'b0, mag[a]} + HALF;
         rnd[a]      = rsum[a][PW:F];
         out_axis[a] = pos_ff[a][PW-1] ? (rnd[a] != '0) : (rnd[a] >= RW'(GRID_SIZE));
         coord[a]    = rnd[a][CW-1:0];
      end
   end

   always_comb begin
      probe_in = probe_ff;
      addr_in  = addr_ff;
      if (flush) begin
         probe_in.valid = 1'b0;
      end else if (!stall) begin
         probe_in.valid   = active_ff;
         probe_in.outside = |out_axis;
         probe_in.last    = last_step;
         probe_in.step    = step_ff;
         addr_in          = {coord[0], coord[1], coord[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         probe_ff  <= '0;
      end else begin
         active_ff <= active_in;
         probe_ff  <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      dir_ff  <= dir_in;
      step_ff <= step_in;
      addr_ff <= addr_in;
   end

   assign active = active_ff;
   assign probe  = probe_ff;
   assign addr   = addr_ff;

endmodule

FILE: rtl/voxel_ray_march.sv
// ----------------------------------------------------------------------------
// voxel_ray_march
// Fixed-step ray marcher over a cubic grid of 4-bit voxel colours.
// ----------------------------------------------------------------------------
// Requests come in on req_if. A write request stores one voxel in the cycle
// it is taken and gives no response. A cast request marches a ray one step
// per cycle through the voxel memory and returns one response on rsp_if:
// first nonzero colour, the out_of_range flag, or colour 0 after the last step.
// The whole grid must be written before rays are cast.
// A cast uses the single memory read port, one read per step. One request is
// in work at a time; req_if.ready is low while a cast runs. The response sits
// in an output register; while it waits, a further write or cast is taken,
// and that cast's march holds once a step reaches the check, until the
// register frees up. Reset clears the control state and sets render_distance
// to 50; the voxel memory is not cleared. csr_wr_data written with csr_wr_en
// sets render_distance (0 acts as 1); write it only while the block is idle.
// ----------------------------------------------------------------------------
module voxel_ray_march import vrm_pkg::*; #(
   parameter int GRID_SIZE     = 128,
   parameter int DIR_FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   vrm_req_if.sink           req_if,
   vrm_rsp_if.source         rsp_if,
   input  logic              csr_wr_en,
   input  logic [STEP_W-1:0] csr_wr_data
);

   localparam int CW = $clog2(GRID_SIZE);
   localparam int AW = 3 * CW;

   logic [STEP_W-1:0]       render_dist_ff, render_dist_in;
   logic [STEP_W-1:0]       limit;

   logic                    busy;
   logic                    req_fire;
   logic                    cast_start;
   logic                    in_grid;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [COORD_IN_W-1:0]   origin [AXES];
   logic signed [DIR_W-1:0] dir [AXES];

   logic                    stall;
   logic                    flush;
   logic                    step_active;
   probe_type               s1_probe;
   logic [AW-1:0]           s1_addr;
   probe_type               s2_ff, s2_in;
   logic [COLOUR_W-1:0]     rd_data;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COLOUR_W-1:0]     rsp_colour_ff, rsp_colour_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_oor_ff, rsp_oor_in;
   logic [STEP_W-1:0]       rsp_steps_ff, rsp_steps_in;

   // ---- configuration
   always_comb begin
      render_dist_in = render_dist_ff;
      if (csr_wr_en) begin
         render_dist_in = csr_wr_data;
      end
   end

   assign limit = (render_dist_ff == '0) ? STEP_W'(1) : render_dist_ff;

   // ---- request side
   assign busy          = step_active || s1_probe.valid || s2_ff.valid;
   assign req_if.ready  = !busy;
   assign req_fire      = req_if.valid && req_if.ready;
   assign cast_start    = req_fire && (req_if.opcode == OP_CAST);

   assign in_grid = (int'(req_if.voxel_x) < GRID_SIZE) &&
                    (int'(req_if.voxel_y) < GRID_SIZE) &&
                    (int'(req_if.voxel_z) < GRID_SIZE);
   assign wr_en   = req_fire && (req_if.opcode == OP_WRITE) && in_grid;
   assign wr_addr = {CW'(req_if.voxel_x), CW'(req_if.voxel_y), CW'(req_if.voxel_z)};

   assign origin[0] = req_if.origin_x;
   assign origin[1] = req_if.origin_y;
   assign origin[2] = req_if.origin_z;
   assign dir[0]    = req_if.dir_x;
   assign dir[1]    = req_if.dir_y;
   assign dir[2]    = req_if.dir_z;

   // ---- pipe: step/round -> memory read -> check
   vrm_ray_step #(
      .GRID_SIZE     (GRID_SIZE),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .start  (cast_start),
      .origin (origin),
      .dir    (dir),
      .limit  (limit),
      .stall  (stall),
      .flush  (flush),
      .active (step_active),
      .probe  (s1_probe),
      .addr   (s1_addr)
   );

   vrm_voxel_ram #(
      .GRID_SIZE (GRID_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.voxel_value),
      .rd_en   (!stall),
      .rd_addr (s1_addr),
      .rd_data (rd_data)
   );

   // hold the whole pipe while a response waits and a step is at the check
   assign stall = rsp_valid_ff && !rsp_if.ready && s2_ff.valid;
   assign flush = s2_ff.valid && !stall &&
                  (s2_ff.outside || (rd_data != '0) || s2_ff.last);

   always_comb begin
      s2_in = s2_ff;
      if (flush) begin
         s2_in.valid = 1'b0;
      end else if (!stall) begin
         s2_in = s1_probe;
      end
   end

   // ---- response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_oor_in    = rsp_oor_ff;
      rsp_steps_in  = rsp_steps_ff;
      if (flush) begin
         rsp_valid_in  = 1'b1;
         rsp_colour_in = s2_ff.outside ? '0 : rd_data;
         rsp_hit_in    = !s2_ff.outside && (rd_data != '0);
         rsp_oor_in    = s2_ff.outside;
         rsp_steps_in  = s2_ff.step;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         render_dist_ff <= RENDER_DIST_RESET;
         s2_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         render_dist_ff <= render_dist_in;
         s2_ff          <= s2_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_colour_ff <= rsp_colour_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_oor_ff    <= rsp_oor_in;
      rsp_steps_ff  <= rsp_steps_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.colour       = rsp_colour_ff;
   assign rsp_if.hit          = rsp_hit_ff;
   assign rsp_if.out_of_range = rsp_oor_ff;
   assign rsp_if.steps_taken  = rsp_steps_ff;

endmodule
